### rtl/lennard_jones_pair_kernel_core_macros.svh
// ----------------------------------------------------------------------------
// Lennard-Jones pair kernel assertion macros
// Concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LENNARD_JONES_PAIR_KERNEL_CORE_MACROS_SVH
`define LENNARD_JONES_PAIR_KERNEL_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define LJK_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition implies another in the same cycle.
`define LJK_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define LJK_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define LJK_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/ljk_pkg.sv
// ----------------------------------------------------------------------------
// Lennard-Jones pair kernel package
// Shared item type, widths and status codes.
// ----------------------------------------------------------------------------
package ljk_pkg;

    localparam int LJK_DIST_W      = 32;
    localparam int LJK_QUOT_W      = 64;
    localparam int LJK_QUEUE_DEPTH = 2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_SAT  = 2'd1;
    localparam t_status ST_ZERO = 2'd2;

    typedef struct packed {
        logic [31:0] distance;
        logic [31:0] sigma;
        logic [31:0] epsilon;
        logic        zero_dist;
        logic        eps_zero;
    } t_item;

endpackage

### rtl/ljk_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; a new division may enter every cycle.
// ----------------------------------------------------------------------------
module ljk_div import ljk_pkg::*; #(
    parameter int DW = LJK_DIST_W,
    parameter int QW = LJK_QUOT_W,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_div,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [QW-1:0] o_quot,
    output logic [TW-1:0] o_tag
);

    logic          r_vld [QW];
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_lq  [QW];
    logic [DW-1:0] r_div [QW];
    logic [TW-1:0] r_tag [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic          vld_in;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] lq_in;
        logic [DW-1:0] div_in;
        logic [TW-1:0] tag_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          fits;

        if (g == 0) begin : g_head
            assign vld_in = i_vld;
            assign rem_in = i_rem;
            assign lq_in  = i_low;
            assign div_in = i_div;
            assign tag_in = i_tag;
        end else begin : g_body
            assign vld_in = r_vld[g-1];
            assign rem_in = r_rem[g-1];
            assign lq_in  = r_lq[g-1];
            assign div_in = r_div[g-1];
            assign tag_in = r_tag[g-1];
        end

        assign trial = {rem_in, lq_in[QW-1]};
        assign diff  = trial - {1'b0, div_in};
        assign fits  = trial >= {1'b0, div_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_in;
            end
            r_rem[g] <= fits ? diff[DW-1:0] : trial[DW-1:0];
            r_lq[g]  <= {lq_in[QW-2:0], fits};
            r_div[g] <= div_in;
            r_tag[g] <= tag_in;
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quot = r_lq[QW-1];
    assign o_tag  = r_tag[QW-1];

endmodule

### rtl/ljk_front.sv
// ----------------------------------------------------------------------------
// Lennard-Jones kernel front end
// Accept items, flag zero distance and zero well depth, hand them to the queue.
// ----------------------------------------------------------------------------
module ljk_front import ljk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_distance,
    input  logic [31:0] i_sigma,
    input  logic [31:0] i_epsilon,
    input  logic        i_full,
    output logic        o_busy,
    output logic        o_push,
    output t_item       o_item
);

    logic  r_vld;
    t_item r_item;
    logic  accept;
    logic  pushing;

    assign o_busy  = r_vld & i_full;
    assign accept  = i_start & ~o_busy;
    assign pushing = r_vld & ~i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (pushing) begin
            r_vld <= 1'b0;
        end
        if (accept) begin
            r_item.distance  <= i_distance;
            r_item.sigma     <= i_sigma;
            r_item.epsilon   <= i_epsilon;
            r_item.zero_dist <= (i_distance == 32'd0);
            r_item.eps_zero  <= (i_epsilon == 32'd0);
        end
    end

    assign o_push = r_vld;
    assign o_item = r_item;

endmodule

### rtl/ljk_queue.sv
// ----------------------------------------------------------------------------
// Lennard-Jones kernel item queue
// Short FIFO between front end and arithmetic back end.
// ----------------------------------------------------------------------------
module ljk_queue import ljk_pkg::*; #(
    parameter int DEPTH = LJK_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

### rtl/ljk_back.sv
// ----------------------------------------------------------------------------
// Lennard-Jones kernel back end
// Ratio divide, power chain, scaling, derivative divides and saturation.
// ----------------------------------------------------------------------------
module ljk_back import ljk_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  t_item        i_item,
    output logic         o_vld,
    output logic [63:0]  o_energy,
    output logic [63:0]  o_first_derivative,
    output logic [63:0]  o_second_derivative,
    output t_status      o_status
);

    typedef struct packed {
        logic [31:0] pair_dist;
        logic [31:0] eps;
        logic        zero_dist;
        logic        eps_zero;
    } t_meta;

    typedef struct packed {
        logic        huge;
        logic        zero_dist;
        logic        eps_zero;
        logic        sat_e;
        logic [63:0] energy;
        logic        ovs;
        logic        negs;
    } t_tail;

    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        return {32'b0, a} * {32'b0, b};
    endfunction

    // {saturated, two's complement value} from a magnitude and a sign
    function automatic logic [64:0] sat_out(input logic ov, input logic [63:0] mag,
                                            input logic neg);
        logic [63:0] limit;
        limit = neg ? NEG_MIN : POS_MAX;
        if (ov || mag > limit) begin
            return {1'b1, limit};
        end
        return {1'b0, neg ? (~mag + 64'd1) : mag};
    endfunction

    // ratio q = sigma / distance in Q.32
    t_meta       qd_meta_in;
    t_meta       qd_meta;
    logic        qd_vld;
    logic [63:0] qd_q;

    assign qd_meta_in.pair_dist = i_item.distance;
    assign qd_meta_in.eps       = i_item.epsilon;
    assign qd_meta_in.zero_dist = i_item.zero_dist;
    assign qd_meta_in.eps_zero  = i_item.eps_zero;

    ljk_div #(.DW(LJK_DIST_W), .QW(LJK_QUOT_W), .TW($bits(t_meta))) u_div_ratio (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (i_vld),
        .i_rem  ('0),
        .i_low  ({i_item.sigma, 32'b0}),
        .i_div  (i_item.zero_dist ? 32'd1 : i_item.distance),
        .i_tag  (qd_meta_in),
        .o_vld  (qd_vld),
        .o_quot (qd_q),
        .o_tag  (qd_meta)
    );

    // stage 1: partials of q*q
    logic        r1_vld;
    t_meta       r1_meta;
    logic [63:0] r1_q;
    logic [63:0] r1_pp [3];
    // stage 2: q2
    logic        r2_vld;
    t_meta       r2_meta;
    logic [63:0] r2_q;
    logic [95:0] r2_q2;
    logic [127:0] s2_sum;
    // stage 3: partials of q2*q
    logic        r3_vld;
    t_meta       r3_meta;
    logic [63:0] r3_pp [6];
    // stage 4: q3
    logic        r4_vld;
    t_meta       r4_meta;
    logic        r4_huge;
    logic [95:0] r4_q3;
    logic [159:0] s4_sum;
    // stage 5: partials of q3*q3
    logic        r5_vld;
    t_meta       r5_meta;
    logic        r5_huge;
    logic [63:0] r5_pp [9];
    // stage 6: q6
    logic        r6_vld;
    t_meta       r6_meta;
    logic        r6_huge;
    logic [95:0] r6_q6;
    logic [191:0] s6_sum;
    // stage 7: partials of q6*q6
    logic        r7_vld;
    t_meta       r7_meta;
    logic        r7_huge;
    logic [95:0] r7_q6;
    logic [63:0] r7_pp [9];
    // stage 8: q12
    logic        r8_vld;
    t_meta       r8_meta;
    logic        r8_huge;
    logic [95:0] r8_q6;
    logic [95:0] r8_q12;
    logic [191:0] s8_sum;
    // stage 9: constant multiples
    logic         r9_vld;
    t_meta        r9_meta;
    logic         r9_huge;
    logic [95:0]  r9_q6;
    logic [95:0]  r9_q12;
    logic [99:0]  r9_f12;
    logic [99:0]  r9_f6;
    logic [103:0] r9_s156;
    logic [103:0] r9_s42;
    // stage 10: signed differences
    logic         r10_vld;
    t_meta        r10_meta;
    logic         r10_huge;
    logic [95:0]  r10_de;
    logic [99:0]  r10_df;
    logic [103:0] r10_ds;
    logic         r10_nege;
    logic         r10_negf;
    logic         r10_negs;
    // stage 11: partials with epsilon, distance squared
    logic         r11_vld;
    t_meta        r11_meta;
    logic         r11_huge;
    logic         r11_nege;
    logic         r11_negf;
    logic         r11_negs;
    logic [63:0]  r11_pe [3];
    logic [63:0]  r11_pf [4];
    logic [63:0]  r11_ps [4];
    logic [63:0]  r11_dd;
    logic [127:0] dfp;
    logic [127:0] dsp;
    // stage 12: scaled magnitudes
    logic         r12_vld;
    t_meta        r12_meta;
    logic         r12_huge;
    logic         r12_nege;
    logic         r12_negf;
    logic         r12_negs;
    logic [127:0] r12_me;
    logic [131:0] r12_mf;
    logic [135:0] r12_ms;
    logic [63:0]  r12_dd;
    logic [127:0] s12_me;
    logic [159:0] s12_mf;
    logic [159:0] s12_ms;
    // stage 13: energy out, divider setup
    logic         r13_vld;
    t_tail        r13_tail;
    logic         r13_ovf;
    logic         r13_negf;
    logic [31:0]  r13_rem_f;
    logic [63:0]  r13_low_f;
    logic [31:0]  r13_div_f;
    logic [63:0]  r13_rem_s;
    logic [63:0]  r13_low_s;
    logic [63:0]  r13_div_s;
    logic [64:0]  s13_e;
    logic         s13_ovf;
    logic         s13_ovs;

    assign s2_sum = 128'(r1_pp[0]) + (128'(r1_pp[1]) << 33) + (128'(r1_pp[2]) << 64);

    always_comb begin
        s4_sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 2; j++) begin
                s4_sum = s4_sum + (160'(r3_pp[i*2+j]) << (32 * (i + j)));
            end
        end
    end

    always_comb begin
        s6_sum = '0;
        s8_sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s6_sum = s6_sum + (192'(r5_pp[i*3+j]) << (32 * (i + j)));
                s8_sum = s8_sum + (192'(r7_pp[i*3+j]) << (32 * (i + j)));
            end
        end
    end

    assign dfp = 128'(r10_df);
    assign dsp = 128'(r10_ds);

    always_comb begin
        s12_me = '0;
        s12_mf = '0;
        s12_ms = '0;
        for (int i = 0; i < 3; i++) begin
            s12_me = s12_me + (128'(r11_pe[i]) << (32 * i));
        end
        for (int i = 0; i < 4; i++) begin
            s12_mf = s12_mf + (160'(r11_pf[i]) << (32 * i));
            s12_ms = s12_ms + (160'(r11_ps[i]) << (32 * i));
        end
    end

    assign s13_e   = sat_out(|r12_me[127:78], r12_me[77:14], r12_nege);
    assign s13_ovf = r12_mf[131:54] >= 78'(r12_meta.pair_dist);
    assign s13_ovs = r12_ms[135:30] >= 106'(r12_dd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
            r13_vld <= 1'b0;
        end else begin
            r1_vld  <= qd_vld;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
            r11_vld <= r10_vld;
            r12_vld <= r11_vld;
            r13_vld <= r12_vld;
        end

        // q*q
        r1_meta  <= qd_meta;
        r1_q     <= qd_q;
        r1_pp[0] <= mul32(qd_q[31:0], qd_q[31:0]);
        r1_pp[1] <= mul32(qd_q[31:0], qd_q[63:32]);
        r1_pp[2] <= mul32(qd_q[63:32], qd_q[63:32]);

        r2_meta <= r1_meta;
        r2_q    <= r1_q;
        r2_q2   <= s2_sum[127:32];

        // q2*q
        r3_meta <= r2_meta;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 2; j++) begin
                r3_pp[i*2+j] <= mul32(r2_q2[32*i +: 32], r2_q[32*j +: 32]);
            end
        end

        r4_meta <= r3_meta;
        r4_huge <= |s4_sum[159:128];
        r4_q3   <= s4_sum[127:32];

        // q3*q3
        r5_meta <= r4_meta;
        r5_huge <= r4_huge;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r5_pp[i*3+j] <= mul32(r4_q3[32*i +: 32], r4_q3[32*j +: 32]);
            end
        end

        r6_meta <= r5_meta;
        r6_huge <= r5_huge | (|s6_sum[191:128]);
        r6_q6   <= s6_sum[127:32];

        // q6*q6
        r7_meta <= r6_meta;
        r7_huge <= r6_huge;
        r7_q6   <= r6_q6;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r7_pp[i*3+j] <= mul32(r6_q6[32*i +: 32], r6_q6[32*j +: 32]);
            end
        end

        r8_meta <= r7_meta;
        r8_huge <= r7_huge | (|s8_sum[191:128]);
        r8_q6   <= r7_q6;
        r8_q12  <= s8_sum[127:32];

        // 12, 6, 156 and 42 multiples by shift and add
        r9_meta  <= r8_meta;
        r9_huge  <= r8_huge;
        r9_q6    <= r8_q6;
        r9_q12   <= r8_q12;
        r9_f12   <= (100'(r8_q12) << 3) + (100'(r8_q12) << 2);
        r9_f6    <= (100'(r8_q6) << 2) + (100'(r8_q6) << 1);
        r9_s156  <= (104'(r8_q12) << 7) + (104'(r8_q12) << 4)
                  + (104'(r8_q12) << 3) + (104'(r8_q12) << 2);
        r9_s42   <= (104'(r8_q6) << 5) + (104'(r8_q6) << 3) + (104'(r8_q6) << 1);

        // magnitude and sign of each difference
        r10_meta <= r9_meta;
        r10_huge <= r9_huge;
        r10_nege <= r9_q6 > r9_q12;
        r10_de   <= (r9_q6 > r9_q12) ? (r9_q6 - r9_q12) : (r9_q12 - r9_q6);
        r10_negf <= r9_f6 > r9_f12;
        r10_df   <= (r9_f6 > r9_f12) ? (r9_f6 - r9_f12) : (r9_f12 - r9_f6);
        r10_negs <= r9_s42 > r9_s156;
        r10_ds   <= (r9_s42 > r9_s156) ? (r9_s42 - r9_s156) : (r9_s156 - r9_s42);

        // times epsilon
        r11_meta <= r10_meta;
        r11_huge <= r10_huge;
        r11_nege <= r10_nege;
        r11_negf <= r10_negf;
        r11_negs <= r10_negs;
        for (int i = 0; i < 3; i++) begin
            r11_pe[i] <= mul32(r10_de[32*i +: 32], r10_meta.eps);
        end
        for (int i = 0; i < 4; i++) begin
            r11_pf[i] <= mul32(dfp[32*i +: 32], r10_meta.eps);
            r11_ps[i] <= mul32(dsp[32*i +: 32], r10_meta.eps);
        end
        r11_dd <= mul32(r10_meta.pair_dist, r10_meta.pair_dist);

        r12_meta <= r11_meta;
        r12_huge <= r11_huge;
        r12_nege <= r11_nege;
        r12_negf <= r11_negf;
        r12_negs <= r11_negs;
        r12_me   <= s12_me;
        r12_mf   <= s12_mf[131:0];
        r12_ms   <= s12_ms[135:0];
        r12_dd   <= r11_dd;

        // energy is final here; derivatives go on to the dividers
        r13_tail.huge      <= r12_huge;
        r13_tail.zero_dist <= r12_meta.zero_dist;
        r13_tail.eps_zero  <= r12_meta.eps_zero;
        r13_tail.sat_e     <= s13_e[64];
        r13_tail.energy    <= s13_e[63:0];
        r13_tail.ovs       <= s13_ovs;
        r13_tail.negs      <= r12_negs;
        r13_ovf   <= s13_ovf;
        r13_negf  <= r12_negf;
        r13_rem_f <= s13_ovf ? 32'd0 : r12_mf[85:54];
        r13_low_f <= {r12_mf[53:0], 10'b0};
        r13_div_f <= r12_meta.zero_dist ? 32'd1 : r12_meta.pair_dist;
        r13_rem_s <= s13_ovs ? 64'd0 : r12_ms[93:30];
        r13_low_s <= {r12_ms[29:0], 34'b0};
        r13_div_s <= r12_meta.zero_dist ? 64'd1 : r12_dd;
    end

    // derivative dividers
    logic        df_vld;
    logic [63:0] df_q;
    logic [1:0]  df_tag;
    logic        ds_vld;
    logic [63:0] ds_q;
    t_tail       ds_tail;

    ljk_div #(.DW(LJK_DIST_W), .QW(LJK_QUOT_W), .TW(2)) u_div_first (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r13_vld),
        .i_rem  (r13_rem_f),
        .i_low  (r13_low_f),
        .i_div  (r13_div_f),
        .i_tag  ({r13_ovf, r13_negf}),
        .o_vld  (df_vld),
        .o_quot (df_q),
        .o_tag  (df_tag)
    );

    ljk_div #(.DW(2 * LJK_DIST_W), .QW(LJK_QUOT_W), .TW($bits(t_tail))) u_div_second (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r13_vld),
        .i_rem  (r13_rem_s),
        .i_low  (r13_low_s),
        .i_div  (r13_div_s),
        .i_tag  (r13_tail),
        .o_vld  (ds_vld),
        .o_quot (ds_q),
        .o_tag  (ds_tail)
    );

    logic [64:0] fres;
    logic [64:0] sres;

    // first derivative is negative when the repulsive term wins
    assign fres = sat_out(df_tag[1], df_q, ~df_tag[0]);
    assign sres = sat_out(ds_tail.ovs, ds_q, ds_tail.negs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= df_vld & ds_vld;
        end
        priority if (ds_tail.zero_dist) begin
            o_energy            <= 64'd0;
            o_first_derivative  <= 64'd0;
            o_second_derivative <= 64'd0;
            o_status            <= ST_ZERO;
        end else if (ds_tail.huge && ds_tail.eps_zero) begin
            o_energy            <= 64'd0;
            o_first_derivative  <= 64'd0;
            o_second_derivative <= 64'd0;
            o_status            <= ST_OK;
        end else if (ds_tail.huge) begin
            o_energy            <= POS_MAX;
            o_first_derivative  <= NEG_MIN;
            o_second_derivative <= POS_MAX;
            o_status            <= ST_SAT;
        end else begin
            o_energy            <= ds_tail.energy;
            o_first_derivative  <= fres[63:0];
            o_second_derivative <= sres[63:0];
            o_status            <= (ds_tail.sat_e | fres[64] | sres[64]) ? ST_SAT : ST_OK;
        end
    end

endmodule

### rtl/lennard_jones_pair_kernel_core.sv
// ----------------------------------------------------------------------------
// Lennard-Jones 12-6 pair kernel
// Energy, first and second derivative of the 12-6 potential for one pair.
// ----------------------------------------------------------------------------
// Pulse start with a distance (Q8.24), sigma (Q8.24) and epsilon (Q16.16);
// the item is taken at any edge where start is high and busy is low, and one
// item may be taken every cycle. Each item gives exactly one result, in
// order, on o_energy, o_first_derivative and o_second_derivative (signed
// Q32.32) with o_status, shown for a single cycle under o_valid; the result
// is not held, so capture it on that cycle. The result register loads once
// the item has passed the input register, the queue, the ratio divider,
// the power and scaling pipeline and the derivative dividers. Values that
// do not fit Q32.32 clamp to the nearest extreme and report status 1; a
// zero distance returns zeros with status 2. busy rises only when the queue
// is full.
// ----------------------------------------------------------------------------
`include "lennard_jones_pair_kernel_core_macros.svh"

module lennard_jones_pair_kernel_core import ljk_pkg::*; #(
    parameter int QUEUE_DEPTH = LJK_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_distance,
    input  logic [31:0] i_sigma,
    input  logic [31:0] i_epsilon,
    output logic        o_valid,
    output logic [63:0] o_energy,
    output logic [63:0] o_first_derivative,
    output logic [63:0] o_second_derivative,
    output logic [1:0]  o_status
);

    logic  q_push;
    logic  q_full;
    logic  q_empty;
    t_item f_item;
    t_item q_item;

    // classify and hold one item
    ljk_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_distance(i_distance),
        .i_sigma   (i_sigma),
        .i_epsilon (i_epsilon),
        .i_full    (q_full),
        .o_busy    (busy),
        .o_push    (q_push),
        .o_item    (f_item)
    );

    // back end drains one item per cycle whenever the queue holds one
    ljk_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_item (f_item),
        .o_full (q_full),
        .i_pop  (~q_empty),
        .o_empty(q_empty),
        .o_item (q_item)
    );

    ljk_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_vld              (~q_empty),
        .i_item             (q_item),
        .o_vld              (o_valid),
        .o_energy           (o_energy),
        .o_first_derivative (o_first_derivative),
        .o_second_derivative(o_second_derivative),
        .o_status           (o_status)
    );

    // zero distance must come out as all-zero values
    `LJK_ASSERT_IMPLY(a_zero_dist_clean, i_clk, i_rst_n, o_valid && o_status == ST_ZERO, o_energy == 64'd0 && o_first_derivative == 64'd0 && o_second_derivative == 64'd0, "zero distance result carries nonzero values")

    // a saturated status needs at least one clamped value
    `LJK_ASSERT_IMPLY(a_sat_has_limit, i_clk, i_rst_n, o_valid && o_status == ST_SAT, o_energy == 64'h7FFF_FFFF_FFFF_FFFF || o_energy == 64'h8000_0000_0000_0000 || o_first_derivative == 64'h7FFF_FFFF_FFFF_FFFF || o_first_derivative == 64'h8000_0000_0000_0000 || o_second_derivative == 64'h7FFF_FFFF_FFFF_FFFF || o_second_derivative == 64'h8000_0000_0000_0000, "saturation status without a clamped value")

    // busy is never raised while the queue has room
    `LJK_ASSERT_ALWAYS(a_busy_only_full, i_clk, i_rst_n, !busy || q_full, "busy raised with queue space")

endmodule

### test/lennard_jones_pair_kernel_checker.sv
// ----------------------------------------------------------------------------
// Lennard-Jones pair kernel checker
// Watches the item and result ports, predicts each result and compares.
// ----------------------------------------------------------------------------
module lennard_jones_pair_kernel_checker import ljk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_distance,
    input  logic [31:0] i_sigma,
    input  logic [31:0] i_epsilon,
    input  logic        o_valid,
    input  logic [63:0] o_energy,
    input  logic [63:0] o_first_derivative,
    input  logic [63:0] o_second_derivative,
    input  logic [1:0]  o_status,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

    typedef logic [191:0] t_wide;

    typedef struct packed {
        logic [63:0] energy;
        logic [63:0] first_der;
        logic [63:0] second_der;
        t_status     status;
    } t_lj_result;

    t_lj_result lj_results_due[$];
    int         errors = 0;

    assign o_errors  = errors;
    assign o_pending = lj_results_due.size();

    function automatic logic [63:0] clamp_q32(t_wide mag, logic neg, inout logic sat);
        logic [63:0] lim;
        lim = neg ? NEG_MAX : POS_MAX;
        if (mag[191:64] != 0 || mag[63:0] > lim) begin
            sat = 1'b1;
            return lim;
        end
        return neg ? (~mag[63:0] + 64'd1) : mag[63:0];
    endfunction

    function automatic t_wide signed_gap(t_wide a, t_wide b, output logic neg);
        neg = (b > a);
        return neg ? (b - a) : (a - b);
    endfunction

    // All wide math wraps at 192 bits.
    function automatic t_lj_result lj_pair_terms(logic [31:0] pair_dist, logic [31:0] sig,
                                                 logic [31:0] eps);
        t_lj_result r;
        t_wide q, q2, q3, q6, q12, m;
        logic huge, sat, neg;
        huge = 1'b0;
        sat  = 1'b0;
        r    = '0;
        if (pair_dist == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        q   = ({32'd0, sig, 32'd0}) / pair_dist;
        q2  = (q * q) >> 32;
        q3  = (q2 * q) >> 32;
        if (q3[191:96] != 0) huge = 1'b1;
        q6  = huge ? t_wide'(0) : (q3 * q3) >> 32;
        if (!huge && q6[191:96] != 0) huge = 1'b1;
        q12 = huge ? t_wide'(0) : (q6 * q6) >> 32;
        if (!huge && q12[191:96] != 0) huge = 1'b1;
        if (huge) begin
            if (eps != 0) begin
                r.energy     = POS_MAX;
                r.first_der  = NEG_MAX;
                r.second_der = POS_MAX;
                r.status     = ST_SAT;
            end else begin
                r.status = ST_OK;
            end
            return r;
        end
        m = signed_gap(q12, q6, neg);
        m = (m * t_wide'(eps) * t_wide'(4)) >> 16;
        r.energy = clamp_q32(m, neg, sat);
        // the force term flips sign: dE/dr = -(12 q12 - 6 q6) ...
        m = signed_gap(q12 * t_wide'(12), q6 * t_wide'(6), neg);
        m = (m * t_wide'(eps) * t_wide'(4)) << 8;
        m = m / pair_dist;
        r.first_der = clamp_q32(m, !neg, sat);
        m = signed_gap(q12 * t_wide'(156), q6 * t_wide'(42), neg);
        m = (m * t_wide'(eps) * t_wide'(4)) << 32;
        m = (m / pair_dist) / pair_dist;
        r.second_der = clamp_q32(m, neg, sat);
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_lj_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (lj_results_due.size() == 0) begin
                    report_mismatch("unexpected result", o_energy, 64'd0);
                end else begin
                    want = lj_results_due.pop_front();
                    if (o_energy !== want.energy)
                        report_mismatch("energy", o_energy, want.energy);
                    if (o_first_derivative !== want.first_der)
                        report_mismatch("first_derivative", o_first_derivative, want.first_der);
                    if (o_second_derivative !== want.second_der)
                        report_mismatch("second_derivative", o_second_derivative,
                                        want.second_der);
                    if (o_status !== want.status)
                        report_mismatch("status", 64'(o_status), 64'(want.status));
                end
            end
            if (start && !busy)
                lj_results_due.push_back(lj_pair_terms(i_distance, i_sigma, i_epsilon));
        end
    end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Lennard-Jones pair kernel testbench
// Directed corner items, then random pairs with random gaps; a checker
// beside the kernel predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import ljk_pkg::*;

    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 1430;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_distance;
    logic [31:0] i_sigma;
    logic [31:0] i_epsilon;
    logic        o_valid;
    logic [63:0] o_energy;
    logic [63:0] o_first_derivative;
    logic [63:0] o_second_derivative;
    logic [1:0]  o_status;
    int          errors;
    int          pending;

    lennard_jones_pair_kernel_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_distance         (i_distance),
        .i_sigma            (i_sigma),
        .i_epsilon          (i_epsilon),
        .o_valid            (o_valid),
        .o_energy           (o_energy),
        .o_first_derivative (o_first_derivative),
        .o_second_derivative(o_second_derivative),
        .o_status           (o_status)
    );

    lennard_jones_pair_kernel_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_distance         (i_distance),
        .i_sigma            (i_sigma),
        .i_epsilon          (i_epsilon),
        .o_valid            (o_valid),
        .o_energy           (o_energy),
        .o_first_derivative (o_first_derivative),
        .o_second_derivative(o_second_derivative),
        .o_status           (o_status),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the kernel hangs.
    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    // Mostly short gaps, now and then a long one, and runs with none.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    // Drive one item at the falling edge and hold it until the kernel takes it.
    task automatic send_pair(logic [31:0] pair_dist, logic [31:0] sig, logic [31:0] eps);
        int gap;
        start      = 1'b1;
        i_distance = pair_dist;
        i_sigma    = sig;
        i_epsilon  = eps;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Distance close to sigma, where the potential well and the wall live.
    task automatic send_near_well();
        logic [31:0] sig, pair_dist;
        logic [63:0] scaled;
        sig       = $urandom_range(32'h0800_0000, 32'h0010_0000);
        // ratio r/s between about 0.8 and 3.0, in Q.16
        scaled    = (64'(sig) * 64'($urandom_range(32'h3_0000, 32'hCCCC))) >> 16;
        pair_dist = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
        if (pair_dist == 0) pair_dist = 32'd1;
        send_pair(pair_dist, sig, $urandom_range(32'h0010_0000, 32'h0000_0100));
    endtask

    initial begin
        int kind;
        start      = 1'b0;
        i_distance = '0;
        i_sigma    = '0;
        i_epsilon  = '0;
        i_rst_n    = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // zero distance, with and without other fields
        send_pair(32'd0, 32'd0, 32'd0);
        send_pair(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // zero sigma, zero epsilon
        send_pair(32'h0100_0000, 32'd0, 32'h0001_0000);
        send_pair(32'h0100_0000, 32'h0100_0000, 32'd0);
        // huge ratio, eps nonzero and zero
        send_pair(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'd1, 32'hFFFF_FFFF, 32'd0);
        send_pair(32'h0000_1000, 32'h0100_0000, 32'h0001_0000);
        // all ones, equal distance and sigma, minimum of the well
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h0100_0000, 32'h0100_0000, 32'h0001_0000);
        send_pair(32'h011F_5DB3, 32'h0100_0000, 32'h0001_0000);
        // far field, tiny values
        send_pair(32'hFFFF_FFFF, 32'd1, 32'd1);
        send_pair(32'hFF00_0000, 32'h0100_0000, 32'hFFFF_FFFF);
        // near the wall: saturation without a huge ratio
        send_pair(32'h0080_0000, 32'h0100_0000, 32'hFFFF_FFFF);
        send_pair(32'h00C0_0000, 32'h0100_0000, 32'h0100_0000);
        send_pair(32'd1, 32'd1, 32'd1);
        send_pair(32'h0000_0001, 32'h0000_0002, 32'h8000_0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // hold off once until everything in flight has come back
            if (n == RANDOM_ITEMS / 2) begin
                start = 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
            kind = $urandom_range(9);
            if (kind < 6) begin
                send_near_well();
            end else if (kind < 8) begin
                send_pair($urandom, $urandom, $urandom);
            end else if (kind < 9) begin
                send_pair($urandom_range(32'h0100_0000), $urandom, $urandom);
            end else begin
                send_pair(($urandom_range(7) == 0) ? 32'd0 : $urandom,
                          ($urandom_range(3) == 0) ? 32'd0 : $urandom,
                          ($urandom_range(3) == 0) ? 32'd0 : $urandom);
            end
        end
        start = 1'b0;

        // drain everything, then watch for strays
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
